// ----- rtl/core/r5900_dec_pkg.sv -----
package r5900_dec_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OP_W   = 7;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned REG_W  = 5;

    localparam logic [KIND_W-1:0] KIND_NORMAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BRANCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_WARN  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FATAL = 2'd2;

    // register use mask: {link, rd, rt, rs}
    typedef logic [3:0] t_uses;
    localparam t_uses U_NONE = 4'b0000;
    localparam t_uses U_RS   = 4'b0001;
    localparam t_uses U_RT   = 4'b0010;
    localparam t_uses U_RD   = 4'b0100;
    localparam t_uses U_LK   = 4'b1000;
    localparam t_uses U_ST   = U_RS | U_RT;
    localparam t_uses U_TD   = U_RT | U_RD;
    localparam t_uses U_R3   = U_RS | U_RT | U_RD;

    // primary opcodes with sub-tables
    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_REGIMM  = 6'h01;
    localparam logic [5:0] OPC_COP0    = 6'h10;
    localparam logic [5:0] OPC_COP1    = 6'h11;
    localparam logic [5:0] OPC_COP2    = 6'h12;
    localparam logic [5:0] OPC_MMI     = 6'h1c;

    localparam logic [OP_W-1:0] OP_NOP     = 7'd0;
    localparam logic [OP_W-1:0] OP_SLL     = 7'd1;
    localparam logic [OP_W-1:0] OP_SRA     = 7'd2;
    localparam logic [OP_W-1:0] OP_DSRL    = 7'd3;
    localparam logic [OP_W-1:0] OP_DSLL    = 7'd4;
    localparam logic [OP_W-1:0] OP_DSLL32  = 7'd5;
    localparam logic [OP_W-1:0] OP_DSRA32  = 7'd6;
    localparam logic [OP_W-1:0] OP_OR      = 7'd7;
    localparam logic [OP_W-1:0] OP_DADDU   = 7'd8;
    localparam logic [OP_W-1:0] OP_MULT    = 7'd9;
    localparam logic [OP_W-1:0] OP_MULTU   = 7'd10;
    localparam logic [OP_W-1:0] OP_DIV     = 7'd11;
    localparam logic [OP_W-1:0] OP_DIVU    = 7'd12;
    localparam logic [OP_W-1:0] OP_BREAK   = 7'd13;
    localparam logic [OP_W-1:0] OP_MFLO    = 7'd14;
    localparam logic [OP_W-1:0] OP_ADDU    = 7'd15;
    localparam logic [OP_W-1:0] OP_SLT     = 7'd16;
    localparam logic [OP_W-1:0] OP_MOVN    = 7'd17;
    localparam logic [OP_W-1:0] OP_MFHI    = 7'd18;
    localparam logic [OP_W-1:0] OP_SLTU    = 7'd19;
    localparam logic [OP_W-1:0] OP_SUBU    = 7'd20;
    localparam logic [OP_W-1:0] OP_AND     = 7'd21;
    localparam logic [OP_W-1:0] OP_SRL     = 7'd22;
    localparam logic [OP_W-1:0] OP_DSRL32  = 7'd23;
    localparam logic [OP_W-1:0] OP_DSRAV   = 7'd24;
    localparam logic [OP_W-1:0] OP_MOVZ    = 7'd25;
    localparam logic [OP_W-1:0] OP_DSLLV   = 7'd26;
    localparam logic [OP_W-1:0] OP_MFSA    = 7'd27;
    localparam logic [OP_W-1:0] OP_SLLV    = 7'd28;
    localparam logic [OP_W-1:0] OP_SRAV    = 7'd29;
    localparam logic [OP_W-1:0] OP_NOR     = 7'd30;
    localparam logic [OP_W-1:0] OP_SRLV    = 7'd31;
    localparam logic [OP_W-1:0] OP_SYSCALL = 7'd32;
    localparam logic [OP_W-1:0] OP_JR      = 7'd33;
    localparam logic [OP_W-1:0] OP_JALR    = 7'd34;
    localparam logic [OP_W-1:0] OP_BGEZ    = 7'd35;
    localparam logic [OP_W-1:0] OP_BLTZ    = 7'd36;
    localparam logic [OP_W-1:0] OP_MFC0    = 7'd37;
    localparam logic [OP_W-1:0] OP_MTC0    = 7'd38;
    localparam logic [OP_W-1:0] OP_DI      = 7'd39;
    localparam logic [OP_W-1:0] OP_EI      = 7'd40;
    localparam logic [OP_W-1:0] OP_ERET    = 7'd41;
    localparam logic [OP_W-1:0] OP_MTC1    = 7'd42;
    localparam logic [OP_W-1:0] OP_CTC1    = 7'd43;
    localparam logic [OP_W-1:0] OP_CFC2    = 7'd44;
    localparam logic [OP_W-1:0] OP_CTC2    = 7'd45;
    localparam logic [OP_W-1:0] OP_QMFC2   = 7'd46;
    localparam logic [OP_W-1:0] OP_QMTC2   = 7'd47;
    localparam logic [OP_W-1:0] OP_PEXTLW  = 7'd48;
    localparam logic [OP_W-1:0] OP_PADDUW  = 7'd49;
    localparam logic [OP_W-1:0] OP_PMFHI   = 7'd50;
    localparam logic [OP_W-1:0] OP_PMFLO   = 7'd51;
    localparam logic [OP_W-1:0] OP_PCPYLD  = 7'd52;
    localparam logic [OP_W-1:0] OP_POR     = 7'd53;
    localparam logic [OP_W-1:0] OP_PCPYHD  = 7'd54;
    localparam logic [OP_W-1:0] OP_SLTI    = 7'd55;
    localparam logic [OP_W-1:0] OP_LUI     = 7'd56;
    localparam logic [OP_W-1:0] OP_ORI     = 7'd57;
    localparam logic [OP_W-1:0] OP_ADDIU   = 7'd58;
    localparam logic [OP_W-1:0] OP_SW      = 7'd59;
    localparam logic [OP_W-1:0] OP_SD      = 7'd60;
    localparam logic [OP_W-1:0] OP_LBU     = 7'd61;
    localparam logic [OP_W-1:0] OP_ANDI    = 7'd62;
    localparam logic [OP_W-1:0] OP_LD      = 7'd63;
    localparam logic [OP_W-1:0] OP_LW      = 7'd64;
    localparam logic [OP_W-1:0] OP_SLTIU   = 7'd65;
    localparam logic [OP_W-1:0] OP_LB      = 7'd66;
    localparam logic [OP_W-1:0] OP_SWC1    = 7'd67;
    localparam logic [OP_W-1:0] OP_SB      = 7'd68;
    localparam logic [OP_W-1:0] OP_LHU     = 7'd69;
    localparam logic [OP_W-1:0] OP_SH      = 7'd70;
    localparam logic [OP_W-1:0] OP_XORI    = 7'd71;
    localparam logic [OP_W-1:0] OP_LWU     = 7'd72;
    localparam logic [OP_W-1:0] OP_DADDIU  = 7'd73;
    localparam logic [OP_W-1:0] OP_LQ      = 7'd74;
    localparam logic [OP_W-1:0] OP_SQ      = 7'd75;
    localparam logic [OP_W-1:0] OP_LH      = 7'd76;
    localparam logic [OP_W-1:0] OP_LDL     = 7'd77;
    localparam logic [OP_W-1:0] OP_LDR     = 7'd78;
    localparam logic [OP_W-1:0] OP_SDL     = 7'd79;
    localparam logic [OP_W-1:0] OP_SDR     = 7'd80;
    localparam logic [OP_W-1:0] OP_BNE     = 7'd81;
    localparam logic [OP_W-1:0] OP_BEQ     = 7'd82;
    localparam logic [OP_W-1:0] OP_BLEZ    = 7'd83;
    localparam logic [OP_W-1:0] OP_BGTZ    = 7'd84;
    localparam logic [OP_W-1:0] OP_JAL     = 7'd85;
    localparam logic [OP_W-1:0] OP_J       = 7'd86;

    typedef struct packed {
        logic [OP_W-1:0]   op_id;
        logic [KIND_W-1:0] kind;
        logic              likely_flag;
        logic              second_pipe;
        t_uses             uses;
        logic [STAT_W-1:0] status;
    } t_dec;

    function automatic t_dec mk(input logic [OP_W-1:0] op, input logic [KIND_W-1:0] kind,
                                input t_uses uses);
        t_dec d;
        d             = '0;
        d.op_id       = op;
        d.kind        = kind;
        d.uses        = uses;
        d.status      = STAT_OK;
        return d;
    endfunction

    function automatic t_dec fatal();
        t_dec d;
        d        = '0;
        d.status = STAT_FATAL;
        return d;
    endfunction

    function automatic t_dec warn_nop();
        t_dec d;
        d        = '0;
        d.status = STAT_WARN;
        return d;
    endfunction

    function automatic t_dec dec_special(input logic [5:0] funct, input logic [4:0] rt,
                                         input logic [4:0] rd, input logic [4:0] sa);
        t_dec d;
        case (funct)
            6'h00: begin
                if (rt == '0 && rd == '0 && sa == '0) begin
                    d = mk(OP_NOP, KIND_NORMAL, U_NONE);
                end else begin
                    d = mk(OP_SLL, KIND_NORMAL, U_TD);
                end
            end
            6'h03: d = mk(OP_SRA,     KIND_NORMAL, U_TD);
            6'h3a: d = mk(OP_DSRL,    KIND_NORMAL, U_TD);
            6'h38: d = mk(OP_DSLL,    KIND_NORMAL, U_TD);
            6'h3c: d = mk(OP_DSLL32,  KIND_NORMAL, U_TD);
            6'h3f: d = mk(OP_DSRA32,  KIND_NORMAL, U_TD);
            6'h25: d = mk(OP_OR,      KIND_NORMAL, U_R3);
            6'h2d: d = mk(OP_DADDU,   KIND_NORMAL, U_R3);
            6'h18: d = mk(OP_MULT,    KIND_NORMAL, U_R3);
            6'h19: d = mk(OP_MULTU,   KIND_NORMAL, U_R3);
            6'h1a: d = mk(OP_DIV,     KIND_NORMAL, U_ST);
            6'h1b: d = mk(OP_DIVU,    KIND_NORMAL, U_ST);
            6'h0d: d = mk(OP_BREAK,   KIND_NORMAL, U_NONE);
            6'h12: d = mk(OP_MFLO,    KIND_NORMAL, U_RD);
            6'h21: d = mk(OP_ADDU,    KIND_NORMAL, U_R3);
            6'h2a: d = mk(OP_SLT,     KIND_NORMAL, U_R3);
            6'h0b: d = mk(OP_MOVN,    KIND_NORMAL, U_R3);
            6'h10: d = mk(OP_MFHI,    KIND_NORMAL, U_RD);
            6'h2b: d = mk(OP_SLTU,    KIND_NORMAL, U_R3);
            6'h23: d = mk(OP_SUBU,    KIND_NORMAL, U_R3);
            6'h24: d = mk(OP_AND,     KIND_NORMAL, U_R3);
            6'h02: d = mk(OP_SRL,     KIND_NORMAL, U_TD);
            6'h3e: d = mk(OP_DSRL32,  KIND_NORMAL, U_TD);
            6'h17: d = mk(OP_DSRAV,   KIND_NORMAL, U_R3);
            6'h0a: d = mk(OP_MOVZ,    KIND_NORMAL, U_R3);
            6'h14: d = mk(OP_DSLLV,   KIND_NORMAL, U_R3);
            6'h28: d = mk(OP_MFSA,    KIND_NORMAL, U_RD);
            6'h04: d = mk(OP_SLLV,    KIND_NORMAL, U_R3);
            6'h07: d = mk(OP_SRAV,    KIND_NORMAL, U_R3);
            6'h27: d = mk(OP_NOR,     KIND_NORMAL, U_R3);
            6'h06: d = mk(OP_SRLV,    KIND_NORMAL, U_R3);
            6'h0c: d = mk(OP_SYSCALL, KIND_END,    U_NONE);
            6'h0f: d = mk(OP_NOP,     KIND_END,    U_NONE);
            6'h08: d = mk(OP_JR,      KIND_BRANCH, U_RS);
            6'h09: d = mk(OP_JALR,    KIND_BRANCH, U_RS | U_RD);
            default: d = fatal();
        endcase
        return d;
    endfunction

    function automatic t_dec dec_mmi(input logic [5:0] funct, input logic [4:0] sa);
        t_dec d;
        case (funct)
            6'h08: begin
                if (sa == 5'h12) d = mk(OP_PEXTLW, KIND_NORMAL, U_R3);
                else d = fatal();
            end
            6'h28: begin
                if (sa == 5'h10) d = mk(OP_PADDUW, KIND_NORMAL, U_R3);
                else d = fatal();
            end
            6'h09: begin
                if (sa == 5'h08) d = mk(OP_PMFHI, KIND_NORMAL, U_RD);
                else if (sa == 5'h09) d = mk(OP_PMFLO, KIND_NORMAL, U_RD);
                else if (sa == 5'h0e) d = mk(OP_PCPYLD, KIND_NORMAL, U_R3);
                else d = fatal();
            end
            6'h29: begin
                if (sa == 5'h12) d = mk(OP_POR, KIND_NORMAL, U_R3);
                else if (sa == 5'h0e) d = mk(OP_PCPYHD, KIND_NORMAL, U_R3);
                else d = fatal();
            end
            6'h18: begin
                d = mk(OP_MULT, KIND_NORMAL, U_R3);
                d.second_pipe = 1'b1;
            end
            6'h19: begin
                d = mk(OP_MULTU, KIND_NORMAL, U_R3);
                d.second_pipe = 1'b1;
            end
            6'h1a: begin
                d = mk(OP_DIV, KIND_NORMAL, U_ST);
                d.second_pipe = 1'b1;
            end
            6'h1b: begin
                d = mk(OP_DIVU, KIND_NORMAL, U_ST);
                d.second_pipe = 1'b1;
            end
            6'h12: begin
                d = mk(OP_MFLO, KIND_NORMAL, U_RD);
                d.second_pipe = 1'b1;
            end
            6'h10: begin
                d = mk(OP_MFHI, KIND_NORMAL, U_RD);
                d.second_pipe = 1'b1;
            end
            default: d = fatal();
        endcase
        return d;
    endfunction

    function automatic t_dec dec_word(input logic [WORD_W-1:0] w);
        t_dec       d;
        logic [5:0] opc;
        logic [5:0] funct;
        logic [4:0] rs;
        logic [4:0] rt;
        logic [4:0] rd;
        logic [4:0] sa;
        opc   = w[31:26];
        rs    = w[25:21];
        rt    = w[20:16];
        rd    = w[15:11];
        sa    = w[10:6];
        funct = w[5:0];
        case (opc)
            OPC_SPECIAL: d = dec_special(funct, rt, rd, sa);
            OPC_REGIMM: begin
                case (rt)
                    5'h01: d = mk(OP_BGEZ, KIND_BRANCH, U_RS);
                    5'h00: d = mk(OP_BLTZ, KIND_BRANCH, U_RS);
                    5'h02: begin
                        d = mk(OP_BLTZ, KIND_BRANCH, U_RS);
                        d.likely_flag = 1'b1;
                    end
                    5'h03: begin
                        d = mk(OP_BGEZ, KIND_BRANCH, U_RS);
                        d.likely_flag = 1'b1;
                    end
                    default: d = fatal();
                endcase
            end
            OPC_COP0: begin
                if (w[10:0] == '0) begin
                    if (rs == 5'h00) d = mk(OP_MFC0, KIND_NORMAL, U_RT);
                    else if (rs == 5'h04) d = mk(OP_MTC0, KIND_NORMAL, U_RT);
                    else d = fatal();
                end else if (rs == 5'h10) begin
                    case (funct)
                        6'h02: d = mk(OP_NOP,  KIND_NORMAL, U_NONE);
                        6'h39: d = mk(OP_DI,   KIND_NORMAL, U_NONE);
                        6'h38: d = mk(OP_EI,   KIND_NORMAL, U_NONE);
                        6'h18: d = mk(OP_ERET, KIND_END,    U_NONE);
                        default: d = fatal();
                    endcase
                end else begin
                    d = fatal();
                end
            end
            OPC_COP1: begin
                if (rs == 5'h10) d = warn_nop();
                else if (rs == 5'h04) d = mk(OP_MTC1, KIND_NORMAL, U_TD);
                else if (rs == 5'h06) d = mk(OP_CTC1, KIND_NORMAL, U_TD);
                else d = fatal();
            end
            OPC_COP2: begin
                if (rs[4]) d = warn_nop();
                else if (rs == 5'h02) d = mk(OP_CFC2,  KIND_NORMAL, U_TD);
                else if (rs == 5'h06) d = mk(OP_CTC2,  KIND_NORMAL, U_TD);
                else if (rs == 5'h01) d = mk(OP_QMFC2, KIND_NORMAL, U_TD);
                else if (rs == 5'h05) d = mk(OP_QMTC2, KIND_NORMAL, U_TD);
                else d = fatal();
            end
            OPC_MMI: d = dec_mmi(funct, sa);
            6'h0a: d = mk(OP_SLTI,   KIND_NORMAL, U_ST);
            6'h0f: d = mk(OP_LUI,    KIND_NORMAL, U_RT);
            6'h0d: d = mk(OP_ORI,    KIND_NORMAL, U_ST);
            6'h09: d = mk(OP_ADDIU,  KIND_NORMAL, U_ST);
            6'h2b: d = mk(OP_SW,     KIND_NORMAL, U_ST);
            6'h3f: d = mk(OP_SD,     KIND_NORMAL, U_ST);
            6'h24: d = mk(OP_LBU,    KIND_NORMAL, U_ST);
            6'h0c: d = mk(OP_ANDI,   KIND_NORMAL, U_ST);
            6'h37: d = mk(OP_LD,     KIND_NORMAL, U_ST);
            6'h23: d = mk(OP_LW,     KIND_NORMAL, U_ST);
            6'h0b: d = mk(OP_SLTIU,  KIND_NORMAL, U_ST);
            6'h20: d = mk(OP_LB,     KIND_NORMAL, U_ST);
            6'h39: d = mk(OP_SWC1,   KIND_NORMAL, U_RS);
            6'h28: d = mk(OP_SB,     KIND_NORMAL, U_ST);
            6'h25: d = mk(OP_LHU,    KIND_NORMAL, U_ST);
            6'h29: d = mk(OP_SH,     KIND_NORMAL, U_ST);
            6'h0e: d = mk(OP_XORI,   KIND_NORMAL, U_ST);
            6'h27: d = mk(OP_LWU,    KIND_NORMAL, U_ST);
            6'h19: d = mk(OP_DADDIU, KIND_NORMAL, U_ST);
            6'h1e: d = mk(OP_LQ,     KIND_NORMAL, U_ST);
            6'h1f: d = mk(OP_SQ,     KIND_NORMAL, U_ST);
            6'h21: d = mk(OP_LH,     KIND_NORMAL, U_ST);
            6'h1a: d = mk(OP_LDL,    KIND_NORMAL, U_ST);
            6'h1b: d = mk(OP_LDR,    KIND_NORMAL, U_ST);
            6'h2c: d = mk(OP_SDL,    KIND_NORMAL, U_ST);
            6'h2d: d = mk(OP_SDR,    KIND_NORMAL, U_ST);
            6'h2f: d = mk(OP_NOP,    KIND_NORMAL, U_NONE);
            6'h05: d = mk(OP_BNE,    KIND_BRANCH, U_ST);
            6'h15: begin
                d = mk(OP_BNE, KIND_BRANCH, U_ST);
                d.likely_flag = 1'b1;
            end
            6'h04: d = mk(OP_BEQ,    KIND_BRANCH, U_ST);
            6'h14: begin
                d = mk(OP_BEQ, KIND_BRANCH, U_ST);
                d.likely_flag = 1'b1;
            end
            6'h06: d = mk(OP_BLEZ,   KIND_BRANCH, U_RS);
            6'h07: d = mk(OP_BGTZ,   KIND_BRANCH, U_RS);
            6'h03: d = mk(OP_JAL,    KIND_BRANCH, U_LK);
            6'h02: d = mk(OP_J,      KIND_BRANCH, U_NONE);
            default: d = fatal();
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/core/r5900_instruction_decoder.sv -----
// R5900 instruction decoder. Takes one 32-bit instruction word per item and returns one decoded
// item: operation number, kind, likely and pipeline-1 flags, register-use flags, status and the
// rs/rt/rd index fields. A new word is taken every cycle while o_stall is low; each item passes
// through the input register and then the result register, with the whole decode done by the
// logic between them. i_stall on the result side backs up through both registers, and
// o_stall rises only when both hold an item and the result is not taken.
module r5900_instruction_decoder
    import r5900_dec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [WORD_W-1:0] i_instr_word,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OP_W-1:0]   o_op_id,
    output logic [KIND_W-1:0] o_kind,
    output logic              o_likely_flag,
    output logic              o_second_pipe,
    output logic              o_uses_rs,
    output logic              o_uses_rt,
    output logic              o_uses_rd,
    output logic              o_uses_link,
    output logic [STAT_W-1:0] o_status,
    output logic [REG_W-1:0]  o_rs_index,
    output logic [REG_W-1:0]  o_rt_index,
    output logic [REG_W-1:0]  o_rd_index
);

    logic                 r_in_valid;
    logic [WORD_W-1:0]    r_word;
    logic                 r_out_valid;
    t_dec                 r_dec;
    logic [3*REG_W-1:0]   r_out_idx;

    logic out_ready;
    logic in_ready;
    logic in_take;
    logic out_load;
    t_dec n_dec;

    assign out_ready = !r_out_valid || !i_stall;
    assign in_ready  = !r_in_valid || out_ready;
    assign in_take   = i_valid && in_ready;
    assign out_load  = r_in_valid && out_ready;
    assign o_stall   = !in_ready;

    always_comb begin
        n_dec = dec_word(r_word);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_word <= i_instr_word;
        end
        if (out_load) begin
            r_dec     <= n_dec;
            r_out_idx <= r_word[25:11];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_op_id       = r_dec.op_id;
    assign o_kind        = r_dec.kind;
    assign o_likely_flag = r_dec.likely_flag;
    assign o_second_pipe = r_dec.second_pipe;
    assign o_uses_rs     = |(r_dec.uses & U_RS);
    assign o_uses_rt     = |(r_dec.uses & U_RT);
    assign o_uses_rd     = |(r_dec.uses & U_RD);
    assign o_uses_link   = |(r_dec.uses & U_LK);
    assign o_status      = r_dec.status;
    assign o_rs_index    = r_out_idx[3*REG_W-1:2*REG_W];
    assign o_rt_index    = r_out_idx[2*REG_W-1:REG_W];
    assign o_rd_index    = r_out_idx[REG_W-1:0];

endmodule
